[hw/rtl/bal_pkg.sv]
// Package: shared types and constants of the Bezier arc-length resampler.
`timescale 1ns / 1ps
package bal_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int COORD_WIDTH_DEF     = 32;

   localparam int STEP_W  = 31;
   localparam int RES_W   = 16;
   localparam int SLOT_W  = 16;
   localparam int LEN_W   = 48;
   localparam int SQ_IN_W = 31;   // chord legs are scaled below 2^31 before squaring
   localparam int SQ_W    = 2 * SQ_IN_W + 1;
   localparam int ROOT_W  = 32;
   localparam int RT_W    = 64;
   localparam int CNT_W   = 6;
   localparam int OP_W    = 4;
   localparam int CSR_W   = 2;

   localparam logic [STEP_W-1:0] STEP_LENGTH_RST = STEP_W'(65536);
   localparam logic [RES_W-1:0]  RESOLUTION_RST  = RES_W'(50000);
   localparam logic [SLOT_W-1:0] POINT_COUNT_RST = SLOT_W'(1000);

   localparam logic [OP_W-1:0] OP_LAST = OP_W'(8);

   typedef enum logic [1:0] {
      KIND_START   = 2'd0,
      KIND_SEGMENT = 2'd1,
      KIND_TICK    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_STEP_LENGTH = 2'd0,
      CSR_RESOLUTION  = 2'd1,
      CSR_POINT_COUNT = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LERP,
      ST_PREP,
      ST_SQUARE,
      ST_ROOT,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   // de Casteljau sequence on a four-tap shift line: lerp taps 0 and 1, or only rotate
   function automatic logic op_is_rotate(input logic [OP_W-1:0] op);
      return (op == OP_W'(3)) || (op == OP_W'(6)) || (op == OP_W'(7));
   endfunction

endpackage

[hw/rtl/bezier_arc_length_resampler.sv]
// Top level: cubic Bezier path flattener emitting points at equal arc-length spacing.
// Sequence: a tick item runs restoring division for t, bit-serial de Casteljau lerps (x and y
//   lanes in parallel), a prep step, squaring, the square root and an update step, then emits
//   its beats, waiting while the output is held.
// Flow: one item at a time; start, segment and idle ticks complete in the idle state.
// Reset: synchronous, active high; configuration registers return to defaults and the path is cleared.
`timescale 1ns / 1ps
module bezier_arc_length_resampler
   import bal_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
   input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   // kind
   input  logic [1:0]                               req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // out_x, out_y, slot_index, box_min_x, box_max_x, box_min_y, box_max_y
   output logic [((6*COORD_WIDTH+SLOT_W+7)/8)*8-1:0] rsp_tdata,
   // is_tail
   output logic                                     rsp_tuser,
   input  logic                                     csr_we,
   input  logic [CSR_W-1:0]                         csr_addr,
   input  logic [STEP_W-1:0]                        csr_wdata
);

   localparam int CW         = COORD_WIDTH;
   localparam int FB         = COORD_FRAC_BITS;
   localparam int RSP_DATA_W = ((6*CW+SLOT_W+7)/8)*8;
   localparam int ACC_W      = CW + 1 + FB;
   localparam int SHIFT_MAX  = (CW + 1 > SQ_IN_W) ? (CW + 1 - SQ_IN_W) : 0;
   localparam int SH_W       = (SHIFT_MAX > 0) ? $clog2(SHIFT_MAX + 1) : 1;
   localparam int CHORD_W    = ROOT_W + SHIFT_MAX;
   localparam int SUM_W      = ((CHORD_W > LEN_W) ? CHORD_W : LEN_W) + 1;
   localparam logic [LEN_W-1:0]    LEN_MAX = {LEN_W{1'b1}};
   localparam logic signed [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};

   // configuration
   logic [STEP_W-1:0] step_ff;
   logic [RES_W-1:0]  res_ff;
   logic [SLOT_W-1:0] pcount_ff;

   // path state
   logic signed [CW-1:0] cpx_ff [4];
   logic signed [CW-1:0] cpy_ff [4];
   logic signed [CW-1:0] prev_x_ff, prev_y_ff;
   logic [LEN_W-1:0]     walked_ff, thr_ff;
   logic [RES_W-1:0]     k_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic signed [CW-1:0] bminx_ff, bmaxx_ff, bminy_ff, bmaxy_ff;

   // working registers
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [OP_W-1:0]      op_ff;
   logic [RES_W:0]       rem_ff;
   logic [FB-1:0]        t_ff;
   logic signed [CW-1:0] wx_ff [4];
   logic signed [CW-1:0] wy_ff [4];
   logic [ACC_W-1:0]     accx_ff, accy_ff;
   logic [SH_W-1:0]      sh_ff;
   logic [SQ_IN_W-1:0]   sa_ff, sb_ff, qa_ff, qb_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [RT_W-1:0]      rrem_ff, rres_ff, rbit_ff;
   logic                 pend_pt_ff, pend_tail_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                 rsp_tail_ff;

   logic accept, out_free, tick_ok, load_out;
   kind_type kind;

   assign kind     = kind_type'(req_tuser);
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign tick_ok  = (res_ff != '0) && (k_ff < res_ff);

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && kind == KIND_TICK && tick_ok) state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == CNT_W'(FB - 1)) state_in = ST_LERP;
         ST_LERP:   if (op_ff == OP_LAST && cnt_ff == CNT_W'(FB)) state_in = ST_PREP;
         ST_PREP:   state_in = ST_SQUARE;
         ST_SQUARE: if (cnt_ff == CNT_W'(SQ_IN_W - 1)) state_in = ST_ROOT;
         ST_ROOT:   if (cnt_ff == CNT_W'(ROOT_W - 1)) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!pend_pt_ff && !pend_tail_ff) state_in = ST_IDLE;
            else if (out_free && (pend_pt_ff ^ pend_tail_ff)) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      load_out   = (state_ff == ST_EMIT) && out_free && (pend_pt_ff || pend_tail_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------- lerp lanes
   logic signed [CW:0]   dlx, dly;
   logic [CW:0]          magx, magy;
   logic [ACC_W-1:0]     accx_in, accy_in;
   logic [CW:0]          rx, ry;
   logic signed [CW:0]   lx, ly;

   always_comb begin
      dlx  = {wx_ff[1][CW-1], wx_ff[1]} - {wx_ff[0][CW-1], wx_ff[0]};
      dly  = {wy_ff[1][CW-1], wy_ff[1]} - {wy_ff[0][CW-1], wy_ff[0]};
      magx = dlx[CW] ? (CW+1)'(-dlx) : dlx;
      magy = dly[CW] ? (CW+1)'(-dly) : dly;
      accx_in = {accx_ff[ACC_W-2:0], 1'b0} + (t_ff[FB-1] ? ACC_W'(magx) : '0);
      accy_in = {accy_ff[ACC_W-2:0], 1'b0} + (t_ff[FB-1] ? ACC_W'(magy) : '0);
      rx = accx_ff[ACC_W-1:FB];
      ry = accy_ff[ACC_W-1:FB];
      lx = {wx_ff[0][CW-1], wx_ff[0]} + (dlx[CW] ? (CW+1)'(-rx) : rx);
      ly = {wy_ff[0][CW-1], wy_ff[0]} + (dly[CW] ? (CW+1)'(-ry) : ry);
   end

   // ---------------- chord legs
   logic signed [CW:0] cdx, cdy;
   logic [CW:0]        lega, legb, legm;
   logic [SH_W-1:0]    sh;

   always_comb begin
      cdx  = {wx_ff[3][CW-1], wx_ff[3]} - {prev_x_ff[CW-1], prev_x_ff};
      cdy  = {wy_ff[3][CW-1], wy_ff[3]} - {prev_y_ff[CW-1], prev_y_ff};
      lega = cdx[CW] ? (CW+1)'(-cdx) : cdx;
      legb = cdy[CW] ? (CW+1)'(-cdy) : cdy;
      legm = (lega > legb) ? lega : legb;
      sh   = '0;
      for (int i = SQ_IN_W; i <= CW; i++) begin
         if (legm[i]) sh = SH_W'(i - (SQ_IN_W - 1));
      end
   end

   // ---------------- root step and length update
   logic [RT_W-1:0]    rtry;
   logic [CHORD_W-1:0] chord;
   logic [SUM_W-1:0]   wsum, tsum;
   logic [LEN_W-1:0]   walked_new;
   logic [RES_W:0]     rem2;

   always_comb begin
      rtry  = rres_ff + rbit_ff;
      chord = CHORD_W'(rres_ff[ROOT_W-1:0]) << sh_ff;
      wsum  = SUM_W'(walked_ff) + SUM_W'(chord);
      tsum  = SUM_W'(thr_ff) + SUM_W'(step_ff);
      walked_new = (wsum > SUM_W'(LEN_MAX)) ? LEN_MAX : wsum[LEN_W-1:0];
      rem2  = {rem_ff[RES_W-1:0], 1'b0};
   end

   // ---------------- datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_LENGTH_RST;
         res_ff    <= RESOLUTION_RST;
         pcount_ff <= POINT_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_STEP_LENGTH: step_ff   <= csr_wdata;
            CSR_RESOLUTION:  res_ff    <= csr_wdata[RES_W-1:0];
            CSR_POINT_COUNT: pcount_ff <= csr_wdata[SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && kind == KIND_START)) begin
         for (int i = 0; i < 4; i++) begin
            cpx_ff[i] <= '0;
            cpy_ff[i] <= '0;
         end
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         walked_ff <= '0;
         thr_ff    <= reset ? LEN_W'(STEP_LENGTH_RST) : LEN_W'(step_ff);
         k_ff      <= '0;
         slot_ff   <= '0;
         bminx_ff  <= C_MAX;
         bmaxx_ff  <= C_MIN;
         bminy_ff  <= C_MAX;
         bmaxy_ff  <= C_MIN;
         pend_pt_ff   <= 1'b0;
         pend_tail_ff <= 1'b0;
         cnt_ff    <= '0;
         op_ff     <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               op_ff  <= '0;
               if (accept && kind == KIND_SEGMENT) begin
                  for (int i = 0; i < 4; i++) begin
                     cpx_ff[i] <= req_tdata[CW*(2*i)   +: CW];
                     cpy_ff[i] <= req_tdata[CW*(2*i+1) +: CW];
                  end
                  prev_x_ff <= req_tdata[0 +: CW];
                  prev_y_ff <= req_tdata[CW +: CW];
                  k_ff      <= '0;
               end else if (accept && kind == KIND_TICK && tick_ok) begin
                  rem_ff <= {1'b0, k_ff};
                  for (int i = 0; i < 4; i++) begin
                     wx_ff[i] <= cpx_ff[i];
                     wy_ff[i] <= cpy_ff[i];
                  end
                  accx_ff <= '0;
                  accy_ff <= '0;
               end
            end
            ST_DIV: begin
               // restoring division, one quotient bit of t per cycle
               if (rem2 >= {1'b0, res_ff}) begin
                  rem_ff <= rem2 - {1'b0, res_ff};
                  t_ff   <= {t_ff[FB-2:0], 1'b1};
               end else begin
                  rem_ff <= rem2;
                  t_ff   <= {t_ff[FB-2:0], 1'b0};
               end
               cnt_ff <= (cnt_ff == CNT_W'(FB - 1)) ? '0 : cnt_ff + 1'b1;
            end
            ST_LERP: begin
               if (op_is_rotate(op_ff) || cnt_ff == CNT_W'(FB)) begin
                  // advance the shift line; a lerp pushes its result in at the tail
                  wx_ff[0] <= wx_ff[1];
                  wx_ff[1] <= wx_ff[2];
                  wx_ff[2] <= wx_ff[3];
                  wy_ff[0] <= wy_ff[1];
                  wy_ff[1] <= wy_ff[2];
                  wy_ff[2] <= wy_ff[3];
                  wx_ff[3] <= op_is_rotate(op_ff) ? wx_ff[0] : lx[CW-1:0];
                  wy_ff[3] <= op_is_rotate(op_ff) ? wy_ff[0] : ly[CW-1:0];
                  accx_ff  <= '0;
                  accy_ff  <= '0;
                  cnt_ff   <= '0;
                  op_ff    <= op_ff + 1'b1;
               end else begin
                  accx_ff <= accx_in;
                  accy_ff <= accy_in;
                  t_ff    <= {t_ff[FB-2:0], t_ff[FB-1]};
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end
            ST_PREP: begin
               sh_ff <= sh;
               sa_ff <= SQ_IN_W'(lega >> sh);
               sb_ff <= SQ_IN_W'(legb >> sh);
               qa_ff <= SQ_IN_W'(lega >> sh);
               qb_ff <= SQ_IN_W'(legb >> sh);
               sq_ff <= '0;
               cnt_ff <= '0;
            end
            ST_SQUARE: begin
               sq_ff <= {sq_ff[SQ_W-2:0], 1'b0}
                        + (qa_ff[SQ_IN_W-1] ? SQ_W'(sa_ff) : '0)
                        + (qb_ff[SQ_IN_W-1] ? SQ_W'(sb_ff) : '0);
               qa_ff <= {qa_ff[SQ_IN_W-2:0], 1'b0};
               qb_ff <= {qb_ff[SQ_IN_W-2:0], 1'b0};
               cnt_ff <= (cnt_ff == CNT_W'(SQ_IN_W - 1)) ? '0 : cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(SQ_IN_W - 1)) begin
                  rrem_ff <= RT_W'({sq_ff[SQ_W-2:0], 1'b0}
                             + (qa_ff[SQ_IN_W-1] ? SQ_W'(sa_ff) : '0)
                             + (qb_ff[SQ_IN_W-1] ? SQ_W'(sb_ff) : '0));
                  rres_ff <= '0;
                  rbit_ff <= RT_W'(1) << (RT_W - 2);
               end
            end
            ST_ROOT: begin
               if (rrem_ff >= rtry) begin
                  rrem_ff <= rrem_ff - rtry;
                  rres_ff <= (rres_ff >> 1) + rbit_ff;
               end else begin
                  rres_ff <= rres_ff >> 1;
               end
               rbit_ff <= rbit_ff >> 2;
               cnt_ff  <= (cnt_ff == CNT_W'(ROOT_W - 1)) ? '0 : cnt_ff + 1'b1;
            end
            ST_UPDATE: begin
               walked_ff <= walked_new;
               pend_pt_ff <= (walked_new > thr_ff) && (slot_ff < pcount_ff);
               if (walked_new > thr_ff) begin
                  thr_ff <= (tsum > SUM_W'(LEN_MAX)) ? LEN_MAX : tsum[LEN_W-1:0];
                  if (wx_ff[3] < bminx_ff) bminx_ff <= wx_ff[3];
                  if (wx_ff[3] > bmaxx_ff) bmaxx_ff <= wx_ff[3];
                  if (wy_ff[3] < bminy_ff) bminy_ff <= wy_ff[3];
                  if (wy_ff[3] > bmaxy_ff) bmaxy_ff <= wy_ff[3];
               end
               pend_tail_ff <= (k_ff == res_ff - 1'b1) && (pcount_ff != '0);
               prev_x_ff <= wx_ff[3];
               prev_y_ff <= wy_ff[3];
               k_ff      <= k_ff + 1'b1;
            end
            ST_EMIT: begin
               // regular point first, then the tail beat
               if (load_out) begin
                  if (pend_pt_ff) begin
                     pend_pt_ff <= 1'b0;
                     slot_ff    <= slot_ff + 1'b1;
                  end else begin
                     pend_tail_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (reset)         rsp_valid_ff <= 1'b0;
      else if (load_out) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= RSP_DATA_W'({bmaxy_ff, bminy_ff, bmaxx_ff, bminx_ff,
                                     (pend_pt_ff ? slot_ff : pcount_ff - 1'b1),
                                     wy_ff[3], wx_ff[3]});
         rsp_tail_ff <= !pend_pt_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_tail_ff;

   // ---------------- assertions
   a_no_early_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> !$rose(rsp_tvalid))
      else $error("result beat raised right after an accepted item");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ($signed(rsp_tdata[3*CW+SLOT_W-1 -: CW]) <= $signed(rsp_tdata[4*CW+SLOT_W-1 -: CW])))
      else $error("bounding box x inverted on a regular point");

   a_tail_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[2*CW +: SLOT_W] == pcount_ff - 1'b1))
      else $error("tail beat not in the last slot");

endmodule
